// File: design/lottery_scheduler_xorshift_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lottery scheduler core
// Each macro checks a property on the rising edge of clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LOTTERY_SCHEDULER_XORSHIFT_CORE_DEFINES_SVH
`define LOTTERY_SCHEDULER_XORSHIFT_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define LSX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define LSX_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define LSX_ASSERT(lbl, prop, msg)

`define LSX_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// File: design/lsx_pkg.sv
// ----------------------------------------------------------------------------
// lsx_pkg
// Shared types and constants of the lottery scheduler core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsx_pkg;

	localparam logic [31:0] SEED_RESET = 32'd2463534242;
	localparam int          SEED_SH_A  = 13;
	localparam int          SEED_SH_B  = 17;
	localparam int          SEED_SH_C  = 5;

	// Control for the slot ring, shared by every cell.
	typedef struct packed {
		logic shift;
		logic wr_en;
		logic wr_ready;
	} lsx_ring_ctrl_t;

	function automatic logic [31:0] lsx_next_seed(input logic [31:0] s);
		logic [31:0] a;
		logic [31:0] b;
		a = s ^ (s << SEED_SH_A);
		b = a ^ (a >> SEED_SH_B);
		return b ^ (b << SEED_SH_C);
	endfunction

endpackage

// File: design/lsx_cell.sv
// ----------------------------------------------------------------------------
// lsx_cell
// One slot of the ring: a ready flag and a ticket count, loaded from the
// neighboring cell when the ring rotates or from the write port when selected.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsx_cell import lsx_pkg::*; #(
	parameter int TICKET_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lsx_ring_ctrl_t         ctrl,
	input  logic                   wr_sel,
	input  logic [TICKET_BITS-1:0] wr_tickets,
	input  logic                   nbr_ready,
	input  logic [TICKET_BITS-1:0] nbr_tickets,
	output logic                   ready,
	output logic [TICKET_BITS-1:0] tickets
);

	logic                   ready_q;
	logic [TICKET_BITS-1:0] tickets_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q   <= 1'b0;
			tickets_q <= TICKET_BITS'(1);
		end else if (ctrl.shift) begin
			ready_q   <= nbr_ready;
			tickets_q <= nbr_tickets;
		end else if (ctrl.wr_en && wr_sel) begin
			ready_q   <= ctrl.wr_ready;
			tickets_q <= wr_tickets;
		end
	end

	assign ready   = ready_q;
	assign tickets = tickets_q;

endmodule

// File: design/lsx_mod.sv
// ----------------------------------------------------------------------------
// lsx_mod
// Restoring remainder unit: reduces a 32-bit value modulo a nonzero divisor,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lottery_scheduler_xorshift_core_defines.svh"

module lsx_mod #(
	parameter int SUM_W = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [31:0]      dividend,
	input  logic [SUM_W-1:0] divisor,
	output logic             done,
	output logic [SUM_W-1:0] rem
);

	localparam int DVD_W = 32;
	localparam int CNT_W = $clog2(DVD_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [SUM_W-1:0] dsr_q;
	logic [SUM_W-1:0] rem_q;

	logic [SUM_W:0]   trial;
	logic             fits;
	logic [SUM_W-1:0] rem_nxt;
	logic             last;

	// The partial remainder stays below the divisor, so the trial value
	// stays below twice the divisor and one subtract restores it.
	assign trial   = {rem_q, dvd_q[DVD_W-1]};
	assign fits    = trial >= {1'b0, dsr_q};
	assign rem_nxt = fits ? SUM_W'(trial - {1'b0, dsr_q}) : trial[SUM_W-1:0];
	assign last    = cnt_q == CNT_W'(DVD_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	`LSX_ASSERT(a_mod_rem_below, busy_q |-> (rem_q < dsr_q), "remainder reached divisor")
	`LSX_ASSERT(a_mod_start_busy, start |=> busy_q, "start did not make the unit busy")
	`LSX_ASSERT(a_mod_finish, (busy_q && last && !start) |=> (done_q && !busy_q), "no finish")

endmodule

// File: design/lottery_scheduler_xorshift_core.sv
// ----------------------------------------------------------------------------
// lottery_scheduler_xorshift_core
// Lottery arbiter over NUM_SLOTS slots. The slots sit in a ring of cells that
// rotates one position per cycle past a single head while a draw sums or walks.
// An update transaction writes one slot directly. A draw rotates the ring once
// to sum the tickets of ready slots, steps the xorshift seed, reduces it modulo
// the sum in a bit-serial remainder unit, then rotates the ring once more to
// find the winner. A draw with no ready slot ends after the sum. One
// transaction is in work at a time; the next one is taken while the result
// waits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lottery_scheduler_xorshift_core_defines.svh"

module lottery_scheduler_xorshift_core import lsx_pkg::*; #(
	parameter int NUM_SLOTS   = 16,
	parameter int TICKET_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [3:0]  slot,
	input  logic        ready_req,
	input  logic [15:0] ticket_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        granted,
	output logic [3:0]  winner
);

	localparam int IDX_W = $clog2(NUM_SLOTS);
	localparam int SUM_W = TICKET_BITS + IDX_W;
	localparam int WIN_W = (IDX_W > 4) ? IDX_W : 4;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUM  = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_WALK = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] cnt_q;
	logic             found_q;
	logic             res_granted_q;
	logic             out_valid_q;
	logic [31:0]      seed_q;
	logic [SUM_W-1:0] total_q;
	logic [SUM_W-1:0] draw_q;
	logic [IDX_W-1:0] win_q;
	logic             granted_q;
	logic [3:0]       winner_q;

	logic                   accept;
	logic [TICKET_BITS-1:0] tix_trunc;
	logic [TICKET_BITS-1:0] wr_tix;
	logic                   slot_ok;
	lsx_ring_ctrl_t         ring_ctrl;
	logic [NUM_SLOTS-1:0]   cell_sel;
	logic [NUM_SLOTS-1:0]   cell_rdy;
	logic [TICKET_BITS-1:0] cell_tix [NUM_SLOTS];
	logic                   head_rdy;
	logic [SUM_W-1:0]       head_ext;
	logic                   walk_last;
	logic                   hit;
	logic                   out_free;
	logic [31:0]            seed_nxt;
	logic                   mod_start;
	logic                   mod_done;
	logic [SUM_W-1:0]       mod_rem;
	logic [WIN_W-1:0]       win_ext;

	assign in_stall  = state_q != ST_IDLE;
	assign accept    = in_valid && !in_stall;
	assign tix_trunc = TICKET_BITS'(ticket_count);
	assign wr_tix    = (tix_trunc == '0) ? TICKET_BITS'(1) : tix_trunc;
	assign slot_ok   = 32'(slot) < 32'(NUM_SLOTS);

	assign ring_ctrl.shift    = (state_q == ST_SUM) || (state_q == ST_WALK);
	assign ring_ctrl.wr_en    = accept && !func && slot_ok;
	assign ring_ctrl.wr_ready = ready_req;

	// Cell i loads from cell i+1, so after k shifts the head holds slot k.
	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		localparam int NXT = (i + 1) % NUM_SLOTS;
		assign cell_sel[i] = 32'(slot) == 32'(i);
		lsx_cell #(
			.TICKET_BITS(TICKET_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ring_ctrl),
			.wr_sel     (cell_sel[i]),
			.wr_tickets (wr_tix),
			.nbr_ready  (cell_rdy[NXT]),
			.nbr_tickets(cell_tix[NXT]),
			.ready      (cell_rdy[i]),
			.tickets    (cell_tix[i])
		);
	end

	assign head_rdy  = cell_rdy[0];
	assign head_ext  = SUM_W'(cell_tix[0]);
	assign walk_last = cnt_q == IDX_W'(NUM_SLOTS - 1);
	assign hit       = head_rdy && !found_q && (draw_q < head_ext);
	assign out_free  = !out_valid_q || !out_stall;
	assign seed_nxt  = lsx_next_seed(seed_q);
	assign mod_start = (state_q == ST_CHK) && (total_q != '0);

	lsx_mod #(
		.SUM_W(SUM_W)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.dividend(seed_nxt),
		.divisor (total_q),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			found_q       <= 1'b0;
			res_granted_q <= 1'b0;
			out_valid_q   <= 1'b0;
			seed_q        <= SEED_RESET;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q         <= '0;
						res_granted_q <= 1'b0;
						state_q       <= func ? ST_SUM : ST_DONE;
					end
				end
				ST_SUM: begin
					cnt_q <= walk_last ? '0 : cnt_q + IDX_W'(1);
					if (walk_last) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (total_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						seed_q  <= seed_nxt;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (mod_done) begin
						cnt_q   <= '0;
						found_q <= 1'b0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					cnt_q <= walk_last ? '0 : cnt_q + IDX_W'(1);
					if (hit) begin
						found_q <= 1'b1;
					end
					if (walk_last) begin
						res_granted_q <= 1'b1;
						state_q       <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign win_ext = WIN_W'(win_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			total_q <= '0;
			win_q   <= '0;
		end
		if (state_q == ST_SUM && head_rdy) begin
			total_q <= total_q + head_ext;
		end
		if (state_q == ST_DIV && mod_done) begin
			draw_q <= mod_rem;
		end
		if (state_q == ST_WALK && head_rdy && !found_q) begin
			if (hit) begin
				win_q <= cnt_q;
			end else begin
				draw_q <= draw_q - head_ext;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			granted_q <= res_granted_q;
			winner_q  <= win_ext[3:0];
		end
	end

	assign out_valid = out_valid_q;
	assign granted   = granted_q;
	assign winner    = winner_q;

	`LSX_ASSERT_NEVER(a_seed_zero, seed_q == '0, "xorshift seed reached zero")
	`LSX_ASSERT(a_div_total, (state_q == ST_DIV) |-> (total_q != '0), "reduction with zero total")
	`LSX_ASSERT(a_walk_found, (state_q == ST_WALK && walk_last) |=> found_q, "walk found no winner")

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lottery scheduler core testbench
// Drives slot updates and draws through the valid/stall input channel while a
// ledger tracks the ticket table, ready flags and xorshift seed. Every grant
// that leaves the core is compared with the oldest predicted grant. Both sides
// insert idle cycles at varying rates across three phases.
// ----------------------------------------------------------------------------

module testbench;

	localparam int          SLOTS        = 16;
	localparam logic [31:0] SEED_START   = 32'd2463534242;
	localparam int          XS_LEFT_A    = 13;
	localparam int          XS_RIGHT     = 17;
	localparam int          XS_LEFT_B    = 5;
	localparam int          RANDOM_ITEMS = 1750;
	localparam int          SETTLE       = 80;
	localparam int          STUCK_LIMIT  = 5000;

	typedef enum logic {
		OP_UPDATE = 1'b0,
		OP_DRAW   = 1'b1
	} lottery_op_t;

	typedef struct packed {
		logic       granted;
		logic [3:0] winner;
	} grant_t;

	class lottery_ledger;
		logic [15:0] tickets [SLOTS];
		logic        ready   [SLOTS];
		logic [31:0] seed;
		grant_t      grant_q [$];
		int          errors;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				tickets[i] = 16'd1;
				ready[i]   = 1'b0;
			end
			seed   = SEED_START;
			errors = 0;
		endfunction

		function logic [31:0] step_seed(logic [31:0] v);
			v = v ^ (v << XS_LEFT_A);
			v = v ^ (v >> XS_RIGHT);
			v = v ^ (v << XS_LEFT_B);
			return v;
		endfunction

		function int outstanding();
			return grant_q.size();
		endfunction

		// Applies one accepted transaction and queues the grant it must produce.
		function void note_request(lottery_op_t op, logic [3:0] s, logic r, logic [15:0] t);
			grant_t      res;
			logic [31:0] total;
			logic [31:0] pick;
			res   = '0;
			total = '0;
			if (op == OP_UPDATE) begin
				tickets[s] = (t == 16'd0) ? 16'd1 : t;
				ready[s]   = r;
			end else begin
				for (int i = 0; i < SLOTS; i++)
					if (ready[i])
						total += tickets[i];
				// With nothing ready the seed must not move.
				if (total != 0) begin
					seed = step_seed(seed);
					pick = seed % total;
					for (int i = 0; i < SLOTS; i++) begin
						if (ready[i]) begin
							if (pick < tickets[i]) begin
								res.granted = 1'b1;
								res.winner  = i[3:0];
								break;
							end
							pick -= tickets[i];
						end
					end
				end
			end
			grant_q.push_back(res);
		endfunction

		function void check_grant(logic g, logic [3:0] w);
			grant_t want;
			if (grant_q.size() == 0) begin
				$display("%0t: result with none pending, expected none, actual granted=%0d winner=%0d",
					$time, g, w);
				errors++;
				return;
			end
			want = grant_q.pop_front();
			if (g !== want.granted) begin
				$display("%0t: granted mismatch, expected %0d, actual %0d",
					$time, want.granted, g);
				errors++;
			end
			if (w !== want.winner) begin
				$display("%0t: winner mismatch, expected %0d, actual %0d",
					$time, want.winner, w);
				errors++;
			end
		endfunction
	endclass

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic        func         = OP_UPDATE;
	logic [3:0]  slot         = '0;
	logic        ready_req    = 1'b0;
	logic [15:0] ticket_count = '0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic        granted;
	logic [3:0]  winner;

	int tx_idle_pct = 10;
	int rx_idle_pct = 61;
	int stuck_cycles = 0;
	int sent = 0;

	lottery_ledger ledger = new();

	lottery_scheduler_xorshift_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.slot         (slot),
		.ready_req    (ready_req),
		.ticket_count (ticket_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.granted      (granted),
		.winner       (winner)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			ledger.check_grant(granted, winner);
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Holds the transaction until it is taken; valid stays high for a follow-on.
	task automatic send_item(lottery_op_t op, logic [3:0] s, logic r, logic [15:0] t);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		func         <= op;
		slot         <= s;
		ready_req    <= r;
		ticket_count <= t;
		do @(posedge clk); while (in_stall !== 1'b0);
		ledger.note_request(op, s, r, t);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (ledger.outstanding() != 0);
	endtask

	function automatic logic [15:0] pick_tickets();
		case ($urandom_range(9))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2, 3:    return 16'($urandom_range(65535));
			default: return 16'($urandom_range(12, 1));
		endcase
	endfunction

	initial begin
		int phase;
		int last_phase;
		last_phase = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, zero and full ticket counts, lone winners at both
		// ends of the table, and a table that empties out again.
		send_item(OP_DRAW,   4'd0,  1'b0, 16'd0);
		send_item(OP_UPDATE, 4'd0,  1'b1, 16'd0);
		send_item(OP_DRAW,   4'd15, 1'b1, 16'hFFFF);
		send_item(OP_UPDATE, 4'd15, 1'b1, 16'hFFFF);
		send_item(OP_DRAW,   4'd0,  1'b0, 16'd0);
		send_item(OP_DRAW,   4'd0,  1'b0, 16'd0);
		send_item(OP_UPDATE, 4'd0,  1'b0, 16'hFFFF);
		send_item(OP_DRAW,   4'd0,  1'b0, 16'd0);
		send_item(OP_UPDATE, 4'd7,  1'b1, 16'd1);
		send_item(OP_UPDATE, 4'd8,  1'b1, 16'h8000);
		send_item(OP_DRAW,   4'd0,  1'b0, 16'd0);
		send_item(OP_DRAW,   4'd0,  1'b0, 16'd0);
		send_item(OP_DRAW,   4'd0,  1'b0, 16'd0);
		send_item(OP_UPDATE, 4'd15, 1'b0, 16'd0);
		send_item(OP_DRAW,   4'd0,  1'b0, 16'd0);
		send_item(OP_UPDATE, 4'd7,  1'b0, 16'd5);
		send_item(OP_UPDATE, 4'd8,  1'b0, 16'd0);
		send_item(OP_DRAW,   4'd15, 1'b1, 16'hFFFF);
		send_item(OP_UPDATE, 4'd3,  1'b1, 16'd0);
		send_item(OP_UPDATE, 4'd12, 1'b1, 16'd2);
		send_item(OP_DRAW,   4'd0,  1'b0, 16'd0);
		send_item(OP_DRAW,   4'd0,  1'b0, 16'd0);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			phase = sent * 3 / RANDOM_ITEMS;
			if (phase != last_phase) begin
				drain();
				last_phase = phase;
				tx_idle_pct = (phase == 1) ? 61 : 0;
				rx_idle_pct = (phase == 1) ? 10 : 0;
			end
			if ($urandom_range(99) < 3) begin
				// Clear every ready flag so draws find nothing until a slot is set ready again.
				for (int i = 0; i < SLOTS; i++)
					send_item(OP_UPDATE, 4'(i), 1'b0, pick_tickets());
			end else if ($urandom_range(99) < 45) begin
				send_item(OP_DRAW, 4'($urandom_range(15)), 1'($urandom_range(1)),
					16'($urandom_range(65535)));
			end else begin
				send_item(OP_UPDATE, 4'($urandom_range(15)), ($urandom_range(3) != 0),
					pick_tickets());
			end
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (ledger.errors == 0 && ledger.outstanding() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
